### src/scancode_line_editor_assert.svh
// scancode_line_editor_assert.svh
// assertion macros for the scancode line editor, used by sle_back
// no dependencies; included by sle_back, which carries concurrent checks
`ifndef SCANCODE_LINE_EDITOR_ASSERT_SVH
`define SCANCODE_LINE_EDITOR_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SLE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sle_pkg.sv
// sle_pkg.sv
// shared types, result kind codes and the set-1 keymap for the scancode line editor
// no dependencies; imported by every module of the block
`default_nettype none

package sle_pkg;

    // command classes handed from the front to the back
    typedef enum logic [1:0] {
        CMD_CHAR  = 2'd0,
        CMD_BS    = 2'd1,
        CMD_ENTER = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [6:0] ch;
    } cmd_t;

    // result kinds
    localparam logic [1:0] KIND_ECHO_CHAR = 2'd0;
    localparam logic [1:0] KIND_ECHO_BS   = 2'd1;
    localparam logic [1:0] KIND_ECHO_NL   = 2'd2;
    localparam logic [1:0] KIND_LINE_CHAR = 2'd3;

    // scancodes and ascii codes with special meaning
    localparam logic [7:0] SC_RELEASE   = 8'h80;
    localparam logic [6:0] SC_CODE_MASK = 7'h7F;
    localparam logic [6:0] SC_LSHIFT    = 7'h2A;
    localparam logic [6:0] SC_RSHIFT    = 7'h36;
    localparam logic [6:0] SC_CAPS      = 7'h3A;
    localparam logic [6:0] SC_MAP_END   = 7'd58;
    localparam logic [6:0] ASCII_BS     = 7'h08;
    localparam logic [6:0] ASCII_LF     = 7'h0A;

    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 2;

    // keymap: returns {shifted, plain}, zero for unmapped codes
    function automatic logic [13:0] keymap(input logic [5:0] code);
        logic [13:0] r;
        case (code)
            6'd2:  r = {7'h21, 7'h31};
            6'd3:  r = {7'h40, 7'h32};
            6'd4:  r = {7'h23, 7'h33};
            6'd5:  r = {7'h24, 7'h34};
            6'd6:  r = {7'h25, 7'h35};
            6'd7:  r = {7'h5E, 7'h36};
            6'd8:  r = {7'h26, 7'h37};
            6'd9:  r = {7'h2A, 7'h38};
            6'd10: r = {7'h28, 7'h39};
            6'd11: r = {7'h29, 7'h30};
            6'd12: r = {7'h5F, 7'h2D};
            6'd13: r = {7'h2B, 7'h3D};
            6'd14: r = {7'h08, 7'h08};
            6'd15: r = {7'h09, 7'h09};
            6'd16: r = {7'h51, 7'h71};
            6'd17: r = {7'h57, 7'h77};
            6'd18: r = {7'h45, 7'h65};
            6'd19: r = {7'h52, 7'h72};
            6'd20: r = {7'h54, 7'h74};
            6'd21: r = {7'h59, 7'h79};
            6'd22: r = {7'h55, 7'h75};
            6'd23: r = {7'h49, 7'h69};
            6'd24: r = {7'h4F, 7'h6F};
            6'd25: r = {7'h50, 7'h70};
            6'd26: r = {7'h7B, 7'h5B};
            6'd27: r = {7'h7D, 7'h5D};
            6'd28: r = {7'h0A, 7'h0A};
            6'd30: r = {7'h41, 7'h61};
            6'd31: r = {7'h53, 7'h73};
            6'd32: r = {7'h44, 7'h64};
            6'd33: r = {7'h46, 7'h66};
            6'd34: r = {7'h47, 7'h67};
            6'd35: r = {7'h48, 7'h68};
            6'd36: r = {7'h4A, 7'h6A};
            6'd37: r = {7'h4B, 7'h6B};
            6'd38: r = {7'h4C, 7'h6C};
            6'd39: r = {7'h3A, 7'h3B};
            6'd40: r = {7'h22, 7'h27};
            6'd41: r = {7'h7E, 7'h60};
            6'd43: r = {7'h7C, 7'h5C};
            6'd44: r = {7'h5A, 7'h7A};
            6'd45: r = {7'h58, 7'h78};
            6'd46: r = {7'h43, 7'h63};
            6'd47: r = {7'h56, 7'h76};
            6'd48: r = {7'h42, 7'h62};
            6'd49: r = {7'h4E, 7'h6E};
            6'd50: r = {7'h4D, 7'h6D};
            6'd51: r = {7'h3C, 7'h2C};
            6'd52: r = {7'h3E, 7'h2E};
            6'd53: r = {7'h3F, 7'h2F};
            6'd55: r = {7'h2A, 7'h2A};
            6'd57: r = {7'h20, 7'h20};
            default: r = 14'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### src/sle_front.sv
// sle_front.sv
// input side: modifier tracking, set-1 translation and command classification
// depends on sle_pkg
`default_nettype none

module sle_front
    import sle_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] scancode
    input  wire logic       q_full,
    output logic            q_push,
    output cmd_t            q_cmd
);

    logic       shift_reg, shift_next;
    logic       caps_reg, caps_next;
    logic       accept;
    logic       cmd_valid;
    logic [6:0] code;
    logic [6:0] ch;
    logic [13:0] map_pair;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign code          = s_axis_tdata[6:0] & SC_CODE_MASK;
    assign map_pair      = keymap(code[5:0]);
    assign ch            = (shift_reg ^ caps_reg) ? map_pair[13:7] : map_pair[6:0];

    // classify the scancode and update the modifier flags
    always_comb begin
        shift_next = shift_reg;
        caps_next  = caps_reg;
        cmd_valid  = 1'b0;
        q_cmd.op   = CMD_CHAR;
        q_cmd.ch   = ch;
        if ((s_axis_tdata & SC_RELEASE) != 8'd0) begin
            if (code == SC_LSHIFT || code == SC_RSHIFT) begin
                shift_next = 1'b0;
            end
        end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
            shift_next = 1'b1;
        end else if (code == SC_CAPS) begin
            caps_next = !caps_reg;
        end else if (code < SC_MAP_END && ch != 7'd0) begin
            cmd_valid = 1'b1;
            if (ch == ASCII_LF) begin
                q_cmd.op = CMD_ENTER;
            end else if (ch == ASCII_BS) begin
                q_cmd.op = CMD_BS;
            end
        end
    end

    assign q_push = accept && cmd_valid;

    // modifier flags change only on a transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= 1'b0;
            caps_reg  <= 1'b0;
        end else if (accept) begin
            shift_reg <= shift_next;
            caps_reg  <= caps_next;
        end
    end

endmodule

`default_nettype wire

### src/sle_cmd_fifo.sv
// sle_cmd_fifo.sv
// two-entry command queue between the front and the back
// depends on sle_pkg
`default_nettype none

module sle_cmd_fifo
    import sle_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output logic      empty
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    // pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload slots
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### src/sle_back.sv
// sle_back.sv
// execution side: line buffer, fill count, echo and line emission, limit register
// depends on sle_pkg and scancode_line_editor_assert.svh
`default_nettype none
`include "scancode_line_editor_assert.svh"

module sle_back
    import sle_pkg::*;
#(
    parameter int LINE_MAX = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [6:0]            cfg_wdata,
    input  wire logic                  q_empty,
    input  wire cmd_t                  q_cmd,
    output logic                       q_pop,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [OUT_USER_W-1:0]      m_axis_tuser,
    output logic                       m_axis_tlast
);

    localparam int DEPTH = LINE_MAX - 1;
    localparam int FW    = $clog2(LINE_MAX);
    localparam int AW    = (LINE_MAX > 2) ? $clog2(LINE_MAX - 1) : 1;
    localparam logic [6:0] LIM_MAX = 7'(LINE_MAX);
    localparam logic [6:0] LIM_MIN = 7'd2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ECHO = 4'b0010,
        ST_READ = 4'b0100,
        ST_LINE = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [6:0]      limit_reg;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [FW-1:0]   flush_len_reg, flush_len_next;
    logic [AW-1:0]   rd_idx_reg, rd_idx_next;
    logic [FW-1:0]   cap;
    logic [FW-1:0]   fill_inc;
    logic            taken;

    logic            out_valid_reg, out_valid_next;
    logic [1:0]      out_kind_reg, out_kind_next;
    logic [6:0]      out_char_reg, out_char_next;
    logic            out_end_reg, out_end_next;
    logic [FW-1:0]   out_len_reg, out_len_next;
    logic            out_last_reg, out_last_next;
    logic            load_line;

    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [6:0]      mem_wd;
    logic [6:0]      line_mem [DEPTH];

    // capacity from the saturated limit
    always_comb begin
        if (limit_reg < LIM_MIN) begin
            cap = FW'(LIM_MIN - 7'd1);
        end else if (limit_reg > LIM_MAX) begin
            cap = FW'(LIM_MAX - 7'd1);
        end else begin
            cap = FW'(limit_reg - 7'd1);
        end
    end

    assign fill_inc = fill_reg + FW'(1);
    assign taken    = out_valid_reg && m_axis_tready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    // command execution and line emission sequencer
    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        flush_len_next = flush_len_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_char_next  = out_char_reg;
        out_end_next   = out_end_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;
        load_line      = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = fill_reg[AW-1:0];
        mem_wd         = q_cmd.ch;
        case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    out_char_next  = q_cmd.ch;
                    out_end_next   = 1'b0;
                    out_len_next   = '0;
                    out_last_next  = 1'b1;
                    flush_len_next = '0;
                    case (q_cmd.op)
                        CMD_ENTER: begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_ECHO_NL;
                            out_char_next  = ASCII_LF;
                            out_end_next   = 1'b1;
                            out_len_next   = fill_reg;
                            out_last_next  = (fill_reg == '0);
                            flush_len_next = fill_reg;
                            fill_next      = '0;
                            state_next     = ST_ECHO;
                        end
                        CMD_BS: begin
                            // backspace on an empty line is dropped
                            if (fill_reg != '0) begin
                                out_valid_next = 1'b1;
                                out_kind_next  = KIND_ECHO_BS;
                                out_char_next  = ASCII_BS;
                                fill_next      = fill_reg - FW'(1);
                                state_next     = ST_ECHO;
                            end
                        end
                        CMD_CHAR: begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_ECHO_CHAR;
                            state_next     = ST_ECHO;
                            if (fill_reg >= cap) begin
                                // line already full after a limit change: not stored
                                out_end_next   = 1'b1;
                                out_len_next   = fill_reg;
                                out_last_next  = 1'b0;
                                flush_len_next = fill_reg;
                                fill_next      = '0;
                            end else begin
                                mem_we = 1'b1;
                                if (fill_inc >= cap) begin
                                    out_end_next   = 1'b1;
                                    out_len_next   = fill_inc;
                                    out_last_next  = 1'b0;
                                    flush_len_next = fill_inc;
                                    fill_next      = '0;
                                end else begin
                                    fill_next = fill_inc;
                                end
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ECHO: begin
                if (taken) begin
                    out_valid_next = 1'b0;
                    rd_idx_next    = '0;
                    state_next     = (flush_len_reg != '0) ? ST_READ : ST_IDLE;
                end
            end
            ST_READ: begin
                load_line      = 1'b1;
                out_valid_next = 1'b1;
                out_kind_next  = KIND_LINE_CHAR;
                out_end_next   = 1'b0;
                out_len_next   = '0;
                out_last_next  = ((FW'(rd_idx_reg) + FW'(1)) == flush_len_reg);
                state_next     = ST_LINE;
            end
            ST_LINE: begin
                if (taken) begin
                    out_valid_next = 1'b0;
                    if (out_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg + AW'(1);
                        state_next  = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            limit_reg     <= 7'd64;
            fill_reg      <= '0;
            flush_len_reg <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            flush_len_reg <= flush_len_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // line buffer with registered read into the output character
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[mem_wa] <= mem_wd;
        end
        if (load_line) begin
            out_char_reg <= line_mem[rd_idx_reg];
        end else begin
            out_char_reg <= out_char_next;
        end
        out_kind_reg <= out_kind_next;
        out_end_reg  <= out_end_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00, 6'(out_len_reg), out_end_reg, out_char_reg};

    // a line is emitted only after the fill count has been cleared
    `SLE_ASSERT_NOW(a_flush_fill_clear, aclk, aresetn, (state_reg == ST_READ || state_reg == ST_LINE), (fill_reg == '0), "fill count not cleared during line emission")
    // a command is never taken while a result is still pending
    `SLE_ASSERT_NOW(a_pop_no_pending, aclk, aresetn, q_pop, !out_valid_reg, "command popped with a result pending")
    // the final result of a command returns the sequencer to idle
    `SLE_ASSERT_NEXT(a_last_to_idle, aclk, aresetn, (taken && out_last_reg), (state_reg == ST_IDLE), "sequencer not idle after final result")
    // line characters are read only from written entries
    `SLE_ASSERT_NOW(a_read_in_line, aclk, aresetn, (state_reg == ST_READ), (FW'(rd_idx_reg) < flush_len_reg), "line read beyond stored length")

endmodule

`default_nettype wire

### src/scancode_line_editor.sv
// Scancode line editor: takes set-1 scancode bytes, tracks shift and caps lock,
// translates keys to ASCII and collects them into a line buffer, echoing each
// key and emitting the finished line character by character. A scancode is
// taken by the front and queued in a two-entry command queue; the back picks up
// a command only when idle, sends the echo transfer, and for a completed line
// reads each stored character from the line buffer, then transfers it, while
// the front keeps taking scancodes as long as the queue has room. The line
// buffer needs no clearing after reset. line_limit is written through cfg_we /
// cfg_wdata and is saturated to 2..LINE_MAX.
// depends on sle_pkg, sle_front, sle_cmd_fifo, sle_back
`default_nettype none

module scancode_line_editor
    import sle_pkg::*;
#(
    parameter int LINE_MAX = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [6:0]            cfg_wdata,   // line_limit
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,  // [7:0] scancode
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // [6:0] char_code, [7] line_end,
                                                      // [13:8] line_length, [15:14] zero
    output logic [OUT_USER_W-1:0]      m_axis_tuser,  // [1:0] kind
    output logic                       m_axis_tlast   // last result of a scancode
);

    logic q_push, q_pop, q_full, q_empty;
    cmd_t push_cmd, pop_cmd;

    // front: modifiers and translation
    sle_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    // command queue
    sle_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    // back: line buffer and result generation
    sle_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .q_empty       (q_empty),
        .q_cmd         (pop_cmd),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### test/tb_scancode_line_editor.sv
// tb_scancode_line_editor.sv
// self-checking testbench for the scancode line editor: scancode stream in, echo/line stream out
// depends on sle_pkg and scancode_line_editor
`timescale 1ns / 1ps

module tb_scancode_line_editor;
    import sle_pkg::*;

    localparam int LINE_MAX    = 64;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE      = 150;  // longest line flush plus margin
    localparam int HOLD_CYCLES = 800;

    // make codes used by name in the stimulus
    localparam logic [7:0] KEY_BKSP  = 8'h0E;
    localparam logic [7:0] KEY_ENTER = 8'h1C;
    localparam logic [7:0] KEY_CTRL  = 8'h1D;
    localparam logic [7:0] KEY_ALT   = 8'h38;
    localparam logic [7:0] NO_KEY    = 8'h7F;  // marks an unmapped table slot

    // set-1 key tables indexed by make code 0..57, code 0 in the top byte
    localparam logic [8*58-1:0] PLAIN_KEYS = {
        "\177\177", "1234567890-=", "\010\011", "qwertyuiop[]", "\n\177",
        "asdfghjkl;'\140", "\177\\", "zxcvbnm,./", "\177*\177 "};
    localparam logic [8*58-1:0] SHIFTED_KEYS = {
        "\177\177", "!@#$%^&*()_+", "\010\011", "QWERTYUIOP{}", "\n\177",
        "ASDFGHJKL:\"~", "\177|", "ZXCVBNM<>?", "\177*\177 "};

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] ch;
        logic       line_end;
        logic [5:0] len;
        logic       last;
    } editor_out_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [6:0]            cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    // stimulus and expectations
    logic [7:0]  scancode_q[$];
    editor_out_t expected_out[$];
    int          sc_offered = 0;
    int          sc_accepted = 0;
    int          errors = 0;
    int          cycle_cnt = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    logic        hold_arm = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;

    // editor state as seen by the predictor
    logic [6:0]  limit_q = 7'd64;
    logic        shift_q = 1'b0;
    logic        caps_q = 1'b0;
    logic [5:0]  fill_q = '0;
    logic [6:0]  store_q[63];

    scancode_line_editor #(.LINE_MAX(LINE_MAX)) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // table lookup, zero for unmapped keys
    function automatic logic [6:0] key_char(input logic [5:0] code, input logic upper);
        logic [7:0] c;
        c = upper ? SHIFTED_KEYS[8*(57-code) +: 8] : PLAIN_KEYS[8*(57-code) +: 8];
        return (c == NO_KEY) ? 7'd0 : c[6:0];
    endfunction

    // characters that fit in a line, limit saturated to 2..LINE_MAX
    function automatic logic [6:0] line_capacity(input logic [6:0] lim);
        if (lim < 7'd2)
            return 7'd1;
        if (lim > LINE_MAX)
            return 7'(LINE_MAX - 1);
        return lim - 7'd1;
    endfunction

    task automatic push_out(input logic [1:0] kind, input logic [6:0] ch,
                            input logic line_end, input logic [5:0] len);
        editor_out_t r;
        r.kind = kind;
        r.ch = ch;
        r.line_end = line_end;
        r.len = len;
        r.last = 1'b0;
        expected_out.push_back(r);
    endtask

    // emit the stored line and start a new one
    task automatic flush_line();
        for (int i = 0; i < fill_q; i++)
            push_out(KIND_LINE_CHAR, store_q[i], 1'b0, 6'd0);
        fill_q = '0;
    endtask

    // expected results of one accepted scancode
    task automatic translate_scancode(input logic [7:0] sc);
        logic [6:0]  ch;
        logic [6:0]  cap;
        int          n0;
        editor_out_t r;
        n0 = expected_out.size();
        if (sc[7]) begin
            if (sc[6:0] == SC_LSHIFT || sc[6:0] == SC_RSHIFT)
                shift_q = 1'b0;
        end else if (sc[6:0] == SC_LSHIFT || sc[6:0] == SC_RSHIFT) begin
            shift_q = 1'b1;
        end else if (sc[6:0] == SC_CAPS) begin
            caps_q = ~caps_q;
        end else if (sc[6:0] < SC_MAP_END) begin
            ch = key_char(sc[5:0], shift_q ^ caps_q);
            cap = line_capacity(limit_q);
            if (ch == ASCII_LF) begin
                push_out(KIND_ECHO_NL, ASCII_LF, 1'b1, fill_q);
                flush_line();
            end else if (ch == ASCII_BS) begin
                if (fill_q != 0) begin
                    fill_q = fill_q - 1'b1;
                    push_out(KIND_ECHO_BS, ASCII_BS, 1'b0, 6'd0);
                end
            end else if (ch != 0) begin
                if (fill_q >= cap) begin
                    // limit lowered under the fill: echo only, then flush
                    push_out(KIND_ECHO_CHAR, ch, 1'b1, fill_q);
                    flush_line();
                end else begin
                    store_q[fill_q] = ch;
                    fill_q = fill_q + 1'b1;
                    if (fill_q >= cap) begin
                        push_out(KIND_ECHO_CHAR, ch, 1'b1, fill_q);
                        flush_line();
                    end else begin
                        push_out(KIND_ECHO_CHAR, ch, 1'b0, 6'd0);
                    end
                end
            end
        end
        if (expected_out.size() > n0) begin
            r = expected_out.pop_back();
            r.last = 1'b1;
            expected_out.push_back(r);
        end
    endtask

    // compare one output transfer with the oldest expectation
    task automatic check_result();
        editor_out_t want;
        logic        bad;
        if (expected_out.size() == 0) begin
            if (errors < 10)
                $display("unexpected result: kind %0d char %h end %b len %0d last %b",
                         m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[7],
                         m_axis_tdata[13:8], m_axis_tlast);
            errors++;
        end else begin
            want = expected_out.pop_front();
            bad = (m_axis_tuser != want.kind) || (m_axis_tdata[6:0] != want.ch) ||
                  (m_axis_tdata[7] != want.line_end) || (m_axis_tdata[13:8] != want.len) ||
                  (m_axis_tdata[15:14] != 2'b00) || (m_axis_tlast != want.last);
            if (bad) begin
                if (errors < 10)
                    $display(
                        "mismatch: kind %0d/%0d char %h/%h end %b/%b len %0d/%0d last %b/%b pad %b",
                        want.kind, m_axis_tuser, want.ch, m_axis_tdata[6:0],
                        want.line_end, m_axis_tdata[7], want.len, m_axis_tdata[13:8],
                        want.last, m_axis_tlast, m_axis_tdata[15:14]);
                errors++;
            end
        end
    endtask

    // input and output transfers, sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                translate_scancode(s_axis_tdata);
                sc_accepted <= sc_accepted + 1;
            end
            if (m_axis_tvalid && m_axis_tready)
                check_result();
        end
    end

    // scancode driver, fed from scancode_q
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (sc_offered == sc_accepted) begin
            if (scancode_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_axis_tdata <= scancode_q.pop_front();
                s_axis_tvalid <= 1'b1;
                sc_offered <= sc_offered + 1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // random make code of a character key, tab included
    function automatic logic [7:0] printable_key();
        logic [7:0] c;
        c = 8'($urandom_range(2, 57));
        while (c == KEY_BKSP || c == KEY_ENTER || c == KEY_CTRL || c == KEY_ALT ||
               c[6:0] == SC_LSHIFT || c[6:0] == SC_RSHIFT)
            c = 8'($urandom_range(2, 57));
        return c;
    endfunction

    task automatic type_chars(input int n);
        for (int i = 0; i < n; i++)
            scancode_q.push_back(printable_key());
    endtask

    // mostly typing with editing, some modifiers, releases and noise
    task automatic random_typing(input int n_keys);
        int counted;
        int r;
        counted = 0;
        while (counted < n_keys) begin
            r = $urandom_range(99);
            if (r < 55)
                scancode_q.push_back(printable_key());
            else if (r < 65)
                scancode_q.push_back(KEY_BKSP);
            else if (r < 72)
                scancode_q.push_back(KEY_ENTER);
            else if (r < 80)
                scancode_q.push_back({1'b0, $urandom_range(1) ? SC_LSHIFT : SC_RSHIFT});
            else if (r < 86)
                scancode_q.push_back({1'b1, $urandom_range(1) ? SC_LSHIFT : SC_RSHIFT});
            else if (r < 89)
                scancode_q.push_back({1'b0, SC_CAPS});
            else if (r < 95)
                scancode_q.push_back(SC_RELEASE | 8'($urandom_range(127)));
            else
                scancode_q.push_back(8'($urandom_range(255)));
            counted++;
        end
    endtask

    task automatic set_traffic(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    // wait until every item is taken and every result has arrived
    task automatic drain();
        while (scancode_q.size() != 0 || sc_offered != sc_accepted ||
               expected_out.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_line_limit(input logic [6:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        limit_q = v;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: ignored codes, empty backspace, shift and caps, empty enter
        set_traffic(0, 0);
        scancode_q.push_back(8'h00);
        scancode_q.push_back(8'hFF);
        scancode_q.push_back(8'h3B);
        scancode_q.push_back(8'h7F);
        scancode_q.push_back(KEY_CTRL);
        scancode_q.push_back(KEY_BKSP);
        scancode_q.push_back(8'h1E);
        scancode_q.push_back({1'b0, SC_LSHIFT});
        scancode_q.push_back(8'h02);
        scancode_q.push_back({1'b1, SC_LSHIFT});
        scancode_q.push_back({1'b0, SC_CAPS});
        scancode_q.push_back(8'h10);
        scancode_q.push_back({1'b0, SC_RSHIFT});
        scancode_q.push_back(8'h10);
        scancode_q.push_back({1'b1, SC_RSHIFT});
        scancode_q.push_back({1'b0, SC_CAPS});
        scancode_q.push_back(8'h0F);
        scancode_q.push_back(8'h39);
        scancode_q.push_back(8'h37);
        scancode_q.push_back(KEY_BKSP);
        scancode_q.push_back(KEY_ENTER);
        scancode_q.push_back(KEY_ENTER);
        // left pending so the next limit drops below the fill
        scancode_q.push_back(8'h1E);
        scancode_q.push_back(8'h30);
        scancode_q.push_back(8'h2E);
        drain();

        write_line_limit(7'd2);
        set_traffic(70, 0);
        random_typing(40);
        drain();

        write_line_limit(7'd0);
        set_traffic(0, 70);
        random_typing(20);
        drain();

        write_line_limit(7'd1);
        set_traffic(27, 27);
        random_typing(20);
        drain();

        write_line_limit(7'd127);
        set_traffic(0, 0);
        random_typing(50);
        drain();

        // long receiver hold-off while 62 characters are typed and then entered
        write_line_limit(7'd64);
        set_traffic(0, 0);
        hold_arm = 1'b1;
        type_chars(62);
        scancode_q.push_back(KEY_ENTER);
        random_typing(20);
        drain();

        set_traffic(0, 70);
        random_typing(50);
        drain();

        write_line_limit(7'd3);
        set_traffic(70, 0);
        random_typing(50);
        drain();

        write_line_limit(7'($urandom_range(30, 127)));
        set_traffic(27, 27);
        random_typing(70);
        type_chars(12);
        drain();

        write_line_limit(7'd5);
        set_traffic(0, 0);
        random_typing(50);
        drain();

        if (errors == 0 && expected_out.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### scancode_line_editor.f
+incdir+src
src/sle_pkg.sv
src/sle_front.sv
src/sle_cmd_fifo.sv
src/sle_back.sv
src/scancode_line_editor.sv
test/tb_scancode_line_editor.sv
